[hw/rtl/view_matrix_builder_macros.svh]
// Assertion macros for the view matrix builder checker.
`ifndef VIEW_MATRIX_BUILDER_MACROS_SVH
`define VIEW_MATRIX_BUILDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VMB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("view matrix builder check failed");

// Next-cycle implication, disabled during reset.
`define VMB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("view matrix builder check failed");

`endif

[hw/rtl/vmb_pkg.sv]
// Shared types and constants for the view matrix builder.
package vmb_pkg;

  localparam int MS_BITS  = 30;  // normalized magnitude width
  localparam int SQ_ITERS = 32;  // square root steps, one result bit from two radicand bits each

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COLIN = 2'd1;
  localparam logic [1:0] ST_NULL  = 2'd2;

  localparam logic [2:0] REG_EYE_X   = 3'd0;
  localparam logic [2:0] REG_EYE_Y   = 3'd1;
  localparam logic [2:0] REG_EYE_Z   = 3'd2;
  localparam logic [2:0] REG_PERSP_X = 3'd3;
  localparam logic [2:0] REG_PERSP_Y = 3'd4;
  localparam logic [2:0] REG_PERSP_Z = 3'd5;

  typedef struct packed {
    logic valid;
    logic tiny;   // vector shorter than threshold
  } vmb_unit_st_t;

endpackage

[hw/rtl/vmb_unit.sv]
// Pipelined vector normalizer: magnitude scaling, square root, three dividers.
module vmb_unit import vmb_pkg::*; #(
  parameter int          W         = 66,
  parameter int          FRAC_BITS = 16,
  parameter logic [63:0] EPS       = 64'd1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] vec [3],
  output vmb_unit_st_t        st,
  output logic signed [31:0]  unit_vec [3]
);

  localparam int NCH = (W + 7) / 8;
  localparam int PW  = $clog2(W);
  localparam int NW  = FRAC_BITS + 31;
  localparam int QW  = FRAC_BITS + 1;
  localparam int CW  = W + 32;
  localparam int SW  = 2 * MS_BITS + 2;

  // stage 1: magnitudes
  logic         v1;
  logic [W-1:0] mag1 [3];
  logic [2:0]   sgn1;
  // stage 2: maximum
  logic         v2;
  logic [W-1:0] mag2 [3];
  logic [2:0]   sgn2;
  logic [W-1:0] mx2;
  // stage 3: per-byte leading one
  logic           v3, zero3;
  logic [W-1:0]   mag3 [3];
  logic [2:0]     sgn3;
  logic [NCH-1:0] nz3;
  logic [2:0]     pos3 [NCH];
  // stage 4: leading one position
  logic          v4, zero4;
  logic [W-1:0]  mag4 [3];
  logic [2:0]    sgn4;
  logic [PW-1:0] p4;
  // stage 5: normalized magnitudes
  logic               v5, zero5;
  logic [MS_BITS-1:0] ms5 [3];
  logic [2:0]         sgn5;
  logic [PW-1:0]      p5;
  // stage 6: squares
  logic                 v6, zero6;
  logic [MS_BITS-1:0]   ms6 [3];
  logic [2:0]           sgn6;
  logic [PW-1:0]        p6;
  logic [2*MS_BITS-1:0] sq6 [3];

  // square root pipeline, index 0 holds the sum of squares
  logic               qval  [0:SQ_ITERS];
  logic               qzero [0:SQ_ITERS];
  logic [63:0]        qv    [0:SQ_ITERS];
  logic [63:0]        qr    [0:SQ_ITERS];
  logic [MS_BITS-1:0] qms   [0:SQ_ITERS][0:2];
  logic [2:0]         qsgn  [0:SQ_ITERS];
  logic [PW-1:0]      qp    [0:SQ_ITERS];

  // division pipeline, index 0 holds numerators and threshold result
  logic          dval  [0:QW];
  logic          dtiny [0:QW];
  logic [30:0]   dlen  [0:QW];
  logic [2:0]    dsgn  [0:QW];
  logic [NW-1:0] drem  [0:QW][0:2];
  logic [QW-1:0] dq    [0:QW][0:2];

  logic [W-1:0]       mag_c [3];
  logic [W-1:0]       mx_c;
  logic [NCH*8-1:0]   mxp;
  logic [NCH-1:0]     nz_c;
  logic [2:0]         pos_c [NCH];
  logic [PW-1:0]      p_c;
  logic [PW-1:0]      lsh;
  logic [W-1:0]       shv [3];
  logic [SW-1:0]      sum_c;
  logic [30:0]        len_c;
  logic               tiny_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][W-1] ? (~vec[i] + W'(1)) : vec[i];
    end
  end

  always_comb begin
    mx_c = mag1[0];
    if (mag1[1] > mx_c) mx_c = mag1[1];
    if (mag1[2] > mx_c) mx_c = mag1[2];
  end

  always_comb begin
    mxp = (NCH*8)'(mx2);
    for (int c = 0; c < NCH; c++) begin
      nz_c[c]  = |mxp[c*8 +: 8];
      pos_c[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (mxp[c*8 + b]) pos_c[c] = 3'(b);
      end
    end
  end

  always_comb begin
    p_c = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz3[c]) p_c = PW'(c*8 + int'(pos3[c]));
    end
  end

  // puts the leading one of the largest component at the top bit
  always_comb begin
    lsh = PW'(W-1) - p4;
    for (int i = 0; i < 3; i++) begin
      shv[i] = mag4[i] << lsh;
    end
  end

  assign sum_c = SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);

  // short when len * 2^(p-29) < eps, compared exactly after scaling by 2^29
  always_comb begin
    len_c  = qr[SQ_ITERS][30:0];
    tiny_c = qzero[SQ_ITERS] ||
             ((CW'(len_c) << qp[SQ_ITERS]) < (CW'(EPS) << 29));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; qval[0] <= 1'b0; dval[0] <= 1'b0;
      st.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; qval[0] <= v6; dval[0] <= qval[SQ_ITERS];
      st.valid <= dval[QW];
      st.tiny  <= dtiny[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag_c[i];
        sgn1[i] <= vec[i][W-1];
        mag2[i] <= mag1[i];
        mag3[i] <= mag2[i];
        mag4[i] <= mag3[i];
        ms5[i]  <= shv[i][W-1 -: MS_BITS];
        ms6[i]  <= ms5[i];
        sq6[i]  <= ms5[i] * ms5[i];
        qms[0][i] <= ms6[i];
        drem[0][i] <= (NW'(qms[SQ_ITERS][i]) << FRAC_BITS) + NW'(len_c >> 1);
        dq[0][i]   <= '0;
        unit_vec[i] <= dsgn[QW][i] ? -32'(dq[QW][i]) : 32'(dq[QW][i]);
      end
      sgn2 <= sgn1; sgn3 <= sgn2; sgn4 <= sgn3; sgn5 <= sgn4; sgn6 <= sgn5;
      mx2   <= mx_c;
      zero3 <= (mx2 == '0);
      nz3   <= nz_c;
      pos3  <= pos_c;
      zero4 <= zero3; zero5 <= zero4; zero6 <= zero5;
      p4 <= p_c; p5 <= p4; p6 <= p5;
      qv[0]    <= 64'(sum_c);
      qr[0]    <= '0;
      qsgn[0]  <= sgn6;
      qzero[0] <= zero6;
      qp[0]    <= p6;
      dtiny[0] <= tiny_c;
      dlen[0]  <= len_c;
      dsgn[0]  <= qsgn[SQ_ITERS];
    end
  end

  // one radicand digit per stage
  for (genvar j = 0; j < SQ_ITERS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_ITERS - 1 - j));
    logic [63:0] trial;
    assign trial = qr[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        qval[j+1] <= 1'b0;
      end else if (en) begin
        qval[j+1] <= qval[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (qv[j] >= trial) begin
          qv[j+1] <= qv[j] - trial;
          qr[j+1] <= (qr[j] >> 1) + BIT;
        end else begin
          qv[j+1] <= qv[j];
          qr[j+1] <= qr[j] >> 1;
        end
        for (int i = 0; i < 3; i++) qms[j+1][i] <= qms[j][i];
        qsgn[j+1]  <= qsgn[j];
        qzero[j+1] <= qzero[j];
        qp[j+1]    <= qp[j];
      end
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [NW-1:0] dvs;
    assign dvs = NW'(dlen[j]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dval[j+1] <= 1'b0;
      end else if (en) begin
        dval[j+1] <= dval[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= dvs) begin
            drem[j+1][i] <= drem[j][i] - dvs;
            dq[j+1][i]   <= dq[j][i] | (QW'(1) << K);
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= dq[j][i];
          end
        end
        dtiny[j+1] <= dtiny[j];
        dlen[j+1]  <= dlen[j];
        dsgn[j+1]  <= dsgn[j];
      end
    end
  end

endmodule

[hw/rtl/view_matrix_builder.sv]
// View matrix builder top level: input stages, two normalizers, matrix stages, row output.
//
// Configuration: cfg_we writes cfg_data into register cfg_index (eye x/y/z, then
// perspective x/y/z); write only while no item is in flight.
// Input channel s_*: one transaction per view; tuser is the action (general or look-at),
// tdata carries the normal or target and the up vector.
// Output channel m_*: four row transactions per view (row 0 to 3, tlast on row 3),
// or a single error transaction with status set and tlast high.
// Throughput: the single output channel moves one row per cycle while m_tready is high;
// the pipeline accepts a new item every cycle until the output fills.
// Every pipeline stage shares one advance enable; when the last stage holds an item and
// the row register stays busy the whole pipeline holds, s_tready drops, nothing is lost.
// Reset (rst, synchronous) clears all valid bits, the row counter and the
// configuration registers.
module view_matrix_builder import vmb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // dir_x, dir_y, dir_z, up_x, up_y, up_z
  input  logic [0:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // col0, col1, col2, col3
  output logic [3:0]   m_tuser,   // row_index, status
  output logic         m_tlast
);

  localparam logic signed [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SMAX   = 66'sd2147483647;
  localparam logic signed [65:0] SMIN   = -66'sd2147483648;
  localparam logic [63:0] EPS1 = (64'd1 << FRAC_BITS) / 64'd10000;
  localparam logic [63:0] EPS2 = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;

  function automatic logic signed [65:0] rnd(input logic signed [65:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > SMAX) return 32'sh7fffffff;
    else if (x < SMIN) return 32'sh80000000;
    else return x[31:0];
  endfunction

  logic signed [31:0] eye [3];
  logic signed [31:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye[0] <= '0; eye[1] <= '0; eye[2] <= '0;
      px <= '0; py <= '0; pz <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EYE_X:   eye[0] <= cfg_data;
        REG_EYE_Y:   eye[1] <= cfg_data;
        REG_EYE_Z:   eye[2] <= cfg_data;
        REG_PERSP_X: px <= cfg_data;
        REG_PERSP_Y: py <= cfg_data;
        REG_PERSP_Z: pz <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en, load, last_row;

  // input stages
  logic               s0v, s1v, s2v;
  logic signed [32:0] s0_n [3];
  logic signed [31:0] s0_up [3];
  logic signed [32:0] s1_n [3];
  logic signed [64:0] s1_a [3];
  logic signed [64:0] s1_b [3];
  logic signed [32:0] s2_n [3];
  logic signed [65:0] s2_c [3];

  logic signed [31:0] dir [3];
  logic signed [31:0] upi [3];
  logic               look;

  always_comb begin
    look = s_tuser[0];
    for (int i = 0; i < 3; i++) begin
      dir[i] = s_tdata[i*32 +: 32];
      upi[i] = s_tdata[96 + i*32 +: 32];
    end
  end

  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0v <= 1'b0; s1v <= 1'b0; s2v <= 1'b0;
    end else if (en) begin
      s0v <= s_tvalid; s1v <= s0v; s2v <= s1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_n[i]  <= look ? (33'(dir[i]) - 33'(eye[i])) : 33'(dir[i]);
        s0_up[i] <= look ? ((i == 1) ? ONE_FX : 32'sd0) : upi[i];
        s1_n[i]  <= s0_n[i];
        s2_n[i]  <= s1_n[i];
        s2_c[i]  <= 66'(s1_a[i]) - 66'(s1_b[i]);
      end
      s1_a[0] <= s0_up[1] * s0_n[2];
      s1_b[0] <= s0_up[2] * s0_n[1];
      s1_a[1] <= s0_up[2] * s0_n[0];
      s1_b[1] <= s0_up[0] * s0_n[2];
      s1_a[2] <= s0_up[0] * s0_n[1];
      s1_b[2] <= s0_up[1] * s0_n[0];
    end
  end

  vmb_unit_st_t       uc_st, un_st;
  logic signed [31:0] e1 [3];
  logic signed [31:0] e3 [3];

  vmb_unit #(.W(66), .FRAC_BITS(FRAC_BITS), .EPS(EPS2)) u_cross (
    .clk(clk), .rst(rst), .en(en), .in_valid(s2v), .vec(s2_c),
    .st(uc_st), .unit_vec(e1)
  );

  vmb_unit #(.W(33), .FRAC_BITS(FRAC_BITS), .EPS(EPS1)) u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(s2v), .vec(s2_n),
    .st(un_st), .unit_vec(e3)
  );

  // matrix stages
  logic               p1v, p2v, p3v, p4v;
  logic [1:0]         p1_st, p2_st, p3_st, p4_st;
  logic signed [63:0] p1_t [6];
  logic signed [63:0] p1_pe1 [3];
  logic signed [63:0] p1_pe3 [3];
  logic signed [63:0] p1_qx [3];
  logic signed [63:0] p1_qy [3];
  logic signed [63:0] p1_qz [3];
  logic signed [31:0] p1_e1 [3];
  logic signed [31:0] p1_e3 [3];

  logic signed [31:0] p2_e2 [3];
  logic signed [31:0] p2_e4x, p2_e4z;
  logic signed [31:0] p2_c0 [3];
  logic signed [31:0] p2_c2 [3];
  logic signed [31:0] p2_c3 [3];
  logic signed [63:0] p2_qy [3];

  logic signed [31:0] p3_e4x, p3_e4z;
  logic signed [63:0] p3_pe2 [3];
  logic signed [63:0] p3_zx, p3_zy, p3_zz;
  logic signed [31:0] p3_c0 [3];
  logic signed [31:0] p3_c1 [3];
  logic signed [31:0] p3_c2 [3];
  logic signed [31:0] p3_c3 [3];

  logic [3:0][127:0]  p4_rows;

  logic signed [65:0] d1, d3, d2;
  logic signed [31:0] e4y;

  always_comb begin
    d1  = rnd(66'(p1_pe1[0])) + rnd(66'(p1_pe1[1])) + rnd(66'(p1_pe1[2]));
    d3  = rnd(66'(p1_pe3[0])) + rnd(66'(p1_pe3[1])) + rnd(66'(p1_pe3[2]));
    d2  = rnd(66'(p3_pe2[0])) + rnd(66'(p3_pe2[1])) + rnd(66'(p3_pe2[2]));
    e4y = sat32(-d2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0; p2v <= 1'b0; p3v <= 1'b0; p4v <= 1'b0;
    end else if (en) begin
      p1v <= uc_st.valid; p2v <= p1v; p3v <= p2v; p4v <= p3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // colinear test has priority over null normal
      p1_st <= uc_st.tiny ? ST_COLIN : (un_st.tiny ? ST_NULL : ST_OK);
      p1_t[0] <= e3[1] * e1[2];
      p1_t[1] <= e3[2] * e1[1];
      p1_t[2] <= e3[2] * e1[0];
      p1_t[3] <= e3[0] * e1[2];
      p1_t[4] <= e3[0] * e1[1];
      p1_t[5] <= e3[1] * e1[0];
      for (int i = 0; i < 3; i++) begin
        p1_pe1[i] <= e1[i] * eye[i];
        p1_pe3[i] <= e3[i] * eye[i];
        p1_qx[i]  <= e3[i] * px;
        p1_qy[i]  <= e3[i] * py;
        p1_qz[i]  <= e3[i] * pz;
        p1_e1[i]  <= e1[i];
        p1_e3[i]  <= e3[i];
      end

      p2_st  <= p1_st;
      p2_e4x <= sat32(-d1);
      p2_e4z <= sat32(-d3);
      for (int i = 0; i < 3; i++) begin
        p2_e2[i] <= 32'(rnd(66'(p1_t[2*i]) - 66'(p1_t[2*i+1])));
        p2_c0[i] <= sat32(66'(p1_e1[i]) + rnd(66'(p1_qx[i])));
        p2_c2[i] <= p1_e3[i];
        p2_c3[i] <= sat32(rnd(66'(p1_qz[i])));
        p2_qy[i] <= p1_qy[i];
      end

      p3_st  <= p2_st;
      p3_e4x <= p2_e4x;
      p3_e4z <= p2_e4z;
      p3_zx  <= p2_e4z * px;
      p3_zy  <= p2_e4z * py;
      p3_zz  <= p2_e4z * pz;
      for (int i = 0; i < 3; i++) begin
        p3_pe2[i] <= p2_e2[i] * eye[i];
        p3_c0[i]  <= p2_c0[i];
        p3_c1[i]  <= sat32(66'(p2_e2[i]) + rnd(66'(p2_qy[i])));
        p3_c2[i]  <= p2_c2[i];
        p3_c3[i]  <= p2_c3[i];
      end

      p4_st <= p3_st;
      for (int i = 0; i < 3; i++) begin
        p4_rows[i] <= {p3_c3[i], p3_c2[i], p3_c1[i], p3_c0[i]};
      end
      p4_rows[3] <= {sat32(66'(ONE_FX) + rnd(66'(p3_zz))),
                     p3_e4z,
                     sat32(66'(e4y) + rnd(66'(p3_zy))),
                     sat32(66'(p3_e4x) + rnd(66'(p3_zx)))};
    end
  end

  // row output register
  logic               ov;
  logic [1:0]         cnt;
  logic [1:0]         ost;
  logic [3:0][127:0]  orows;

  assign last_row = (ost != ST_OK) || (cnt == 2'd3);
  assign load     = p4v && (!ov || (m_tready && last_row));
  assign en       = !p4v || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      cnt <= 2'd0;
    end else if (load) begin
      ov  <= 1'b1;
      cnt <= 2'd0;
    end else if (ov && m_tready) begin
      if (last_row) ov <= 1'b0;
      else cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      orows <= p4_rows;
      ost   <= p4_st;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = (ost == ST_OK) ? orows[cnt] : 128'd0;
  assign m_tuser  = {ost, cnt};
  assign m_tlast  = last_row;

endmodule

[hw/rtl/vmb_checker.sv]
// Port-level checker for the view matrix builder, bound to the top level.
`include "view_matrix_builder_macros.svh"

module vmb_checker import vmb_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [3:0]   m_tuser,
  input logic         m_tlast
);

  `VMB_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `VMB_ASSERT_IMP(a_err_shape, clk, rst, m_tvalid && (m_tuser[3:2] != ST_OK), m_tlast && (m_tdata == 128'd0) && (m_tuser[1:0] == 2'd0))
  `VMB_ASSERT_IMP(a_last_row, clk, rst, m_tvalid && m_tlast && (m_tuser[3:2] == ST_OK), m_tuser[1:0] == 2'd3)
  `VMB_ASSERT_NXT(a_row_seq, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1))

endmodule

bind view_matrix_builder vmb_checker u_vmb_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

[sim/vmb_checker.sv]
// Checker for the view matrix builder: watches both channels, predicts rows, compares.
`timescale 1ns / 1ps
module vmb_tb_checker import vmb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,   // dir_x, dir_y, dir_z, up_x, up_y, up_z
  input  logic [0:0]   s_tuser,   // action
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,   // col0, col1, col2, col3
  input  logic [3:0]   m_tuser,   // row_index, status
  input  logic         m_tlast,
  output int           errors,
  output int           pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] col3;
    logic [1:0]  status;
    logic        last;
  } row_t;

  localparam wide_t ONE   = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t EPS_N = (wide_t'(1) <<< FRAC_BITS) / 10000;
  localparam wide_t EPS_C = (wide_t'(1) <<< (2 * FRAC_BITS)) / 10000;

  logic [31:0] view_regs [6];
  row_t expected_rows [$];

  function automatic wide_t sx(input logic [31:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic wide_t round_fx(input wide_t x);
    return (x + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] clamp32(input wide_t x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // returns 1 when the vector is shorter than eps
  function automatic bit normalize(input wide_t v [3], input wide_t eps, output wide_t u [3]);
    wide_t mag [3];
    wide_t ms [3];
    wide_t m, sum, len, q;
    int p, sh;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 1;
    p = 0;
    while ((m >> p) > 1) p++;
    sh = p - 29;
    for (int i = 0; i < 3; i++) begin
      ms[i] = sh >= 0 ? (mag[i] >> sh) : (mag[i] << (-sh));
      sum = sum + ms[i] * ms[i];
    end
    len = wide_t'(floor_sqrt(sum[63:0]));
    if (sh >= 0) begin
      if ((len << sh) < eps) return 1;
    end else if (len < (eps << (-sh))) begin
      return 1;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((ms[i] << FRAC_BITS) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -q : q;
    end
    return 0;
  endfunction

  function automatic wide_t dot_round(input wide_t a [3], input wide_t b [3]);
    return round_fx(a[0] * b[0]) + round_fx(a[1] * b[1]) + round_fx(a[2] * b[2]);
  endfunction

  task automatic predict_view(input logic action, input logic [191:0] d);
    wide_t eye [3];
    wide_t nrm [3];
    wide_t up [3];
    wide_t crs [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t e3 [3];
    wide_t e4 [3];
    wide_t cols [4];
    wide_t px, py, pz;
    logic [1:0] st;
    row_t r;
    px = sx(view_regs[REG_PERSP_X]);
    py = sx(view_regs[REG_PERSP_Y]);
    pz = sx(view_regs[REG_PERSP_Z]);
    for (int i = 0; i < 3; i++) begin
      eye[i] = sx(view_regs[i]);
      nrm[i] = sx(d[32*i +: 32]);
      up[i]  = sx(d[32*(i+3) +: 32]);
    end
    if (action) begin
      for (int i = 0; i < 3; i++) nrm[i] = nrm[i] - eye[i];
      up[0] = 0;
      up[1] = ONE;
      up[2] = 0;
    end
    crs[0] = up[1] * nrm[2] - up[2] * nrm[1];
    crs[1] = up[2] * nrm[0] - up[0] * nrm[2];
    crs[2] = up[0] * nrm[1] - up[1] * nrm[0];
    st = ST_OK;
    // colinearity wins over a null normal
    if (normalize(crs, EPS_C, e1)) st = ST_COLIN;
    else if (normalize(nrm, EPS_N, e3)) st = ST_NULL;
    if (st != ST_OK) begin
      r = '0;
      r.status = st;
      r.last = 1'b1;
      expected_rows.push_back(r);
      return;
    end
    e2[0] = round_fx(e3[1] * e1[2] - e3[2] * e1[1]);
    e2[1] = round_fx(e3[2] * e1[0] - e3[0] * e1[2]);
    e2[2] = round_fx(e3[0] * e1[1] - e3[1] * e1[0]);
    e4[0] = sx(clamp32(-dot_round(e1, eye)));
    e4[1] = sx(clamp32(-dot_round(e2, eye)));
    e4[2] = sx(clamp32(-dot_round(e3, eye)));
    for (int k = 0; k < 4; k++) begin
      if (k < 3) begin
        cols[0] = e1[k] + round_fx(e3[k] * px);
        cols[1] = e2[k] + round_fx(e3[k] * py);
        cols[2] = e3[k];
        cols[3] = round_fx(e3[k] * pz);
      end else begin
        cols[0] = e4[0] + round_fx(e4[2] * px);
        cols[1] = e4[1] + round_fx(e4[2] * py);
        cols[2] = e4[2];
        cols[3] = ONE + round_fx(e4[2] * pz);
      end
      r.row_index = k[1:0];
      r.col0 = clamp32(cols[0]);
      r.col1 = clamp32(cols[1]);
      r.col2 = clamp32(cols[2]);
      r.col3 = clamp32(cols[3]);
      r.status = ST_OK;
      r.last = (k == 3);
      expected_rows.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    row_t got, want;
    if (rst) begin
      for (int i = 0; i < 6; i++) view_regs[i] <= '0;
      expected_rows.delete();
      errors <= 0;
    end else begin
      if (cfg_we && cfg_index < 3'd6) view_regs[cfg_index] <= cfg_data;
      if (s_tvalid && s_tready) predict_view(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) begin
        got.row_index = m_tuser[1:0];
        got.col0 = m_tdata[31:0];
        got.col1 = m_tdata[63:32];
        got.col2 = m_tdata[95:64];
        got.col3 = m_tdata[127:96];
        got.status = m_tuser[3:2];
        got.last = m_tlast;
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row transaction, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            $display("%0t: row mismatch, expected %h, actual %h", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = expected_rows.size();
  end

endmodule

[sim/tb_view_matrix_builder.sv]
// Testbench top for the view matrix builder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_view_matrix_builder import vmb_pkg::*;;

  localparam int FRAC_BITS = 16;
  localparam int DRAIN = FRAC_BITS + 70;
  localparam int LIMIT = 600000;
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam logic ACT_GENERAL = 1'b0;
  localparam logic ACT_LOOKAT = 1'b1;
  localparam logic [31:0] ONE_FX = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [191:0] s_tdata = '0;   // dir_x, dir_y, dir_z, up_x, up_y, up_z
  logic [0:0] s_tuser = '0;     // action
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;        // col0, col1, col2, col3
  logic [3:0] m_tuser;          // row_index, status
  logic m_tlast;

  int errors, pending, cycles;
  logic s_fire = 1'b0, m_fire = 1'b0;
  bit idling = 1'b1;
  int rx_wait = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  view_matrix_builder #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  vmb_tb_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

  always @(posedge clk) begin
    s_fire <= s_tvalid && s_tready;
    m_fire <= m_tvalid && m_tready;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial cycles = 0;

  // receiver stalls drawn per row
  always @(negedge clk) begin
    int w;
    w = rx_wait;
    if (m_fire || w < 0) w = idling ? $urandom_range(0, 11) : 0;
    m_tready <= (w == 0);
    rx_wait <= (w > 0) ? w - 1 : 0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_view(input logic [31:0] ex, ey, ez, px, py, pz);
    write_reg(REG_EYE_X, ex);
    write_reg(REG_EYE_Y, ey);
    write_reg(REG_EYE_Z, ez);
    write_reg(REG_PERSP_X, px);
    write_reg(REG_PERSP_Y, py);
    write_reg(REG_PERSP_Z, pz);
    write_reg(REG_UNUSED, $urandom);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_view(input logic act, input logic [31:0] dx, dy, dz, ux, uy, uz);
    int gap;
    gap = idling ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {uz, uy, ux, dz, dy, dx};
    do @(negedge clk); while (!s_fire);
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [31:0] moderate;
    logic [31:0] v;
    v = $urandom_range(0, 1 << 21);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic random_view;
    int kind, k;
    logic [31:0] dx, dy, dz;
    kind = $urandom_range(0, 9);
    dx = moderate();
    dy = moderate();
    dz = moderate();
    if (kind < 2) begin
      send_view(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end else if (kind < 6) begin
      send_view(ACT_GENERAL, dx, dy, dz, moderate(), moderate(), moderate());
    end else if (kind < 9) begin
      send_view(ACT_LOOKAT, dx, dy, dz, $urandom, $urandom, $urandom);
    end else begin
      // up parallel to the normal, or a tiny normal
      k = $urandom_range(1, 3);
      if ($urandom_range(0, 1))
        send_view(ACT_GENERAL, dx, dy, dz, dx * k, dy * k, dz * k);
      else
        send_view(ACT_GENERAL, $urandom_range(0, 7), 0, $urandom_range(0, 3),
                  $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed views with registers at reset
    send_view(ACT_GENERAL, 0, 0, ONE_FX, 0, ONE_FX, 0);
    send_view(ACT_GENERAL, ONE_FX, ONE_FX, ONE_FX, 0, ONE_FX, 0);
    send_view(ACT_GENERAL, 0, 0, 0, 0, ONE_FX, 0);               // null normal
    send_view(ACT_GENERAL, 0, ONE_FX, 0, 0, 32'hffff_0000, 0);   // colinear
    send_view(ACT_GENERAL, 1, 0, 0, 0, 32'h7fff_ffff, 0);        // short normal
    send_view(ACT_GENERAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_view(ACT_GENERAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_view(ACT_LOOKAT, 0, 0, 0, 0, 0, 0);                      // target at eye
    send_view(ACT_LOOKAT, 0, 32'h0005_0000, 0, 0, 0, 0);          // straight up
    send_view(ACT_LOOKAT, 32'h0003_0000, 32'h0001_0000, 32'hfff8_0000,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_view(ACT_GENERAL, 0, 0, 1, 1, 0, 0);
    settle();

    set_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_view(ACT_LOOKAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_view(ACT_LOOKAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    send_view(ACT_GENERAL, 0, 0, ONE_FX, 0, ONE_FX, 0);
    for (int i = 0; i < 55; i++) random_view();
    settle();

    set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_view(ACT_LOOKAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    idling = 1'b0;
    for (int i = 0; i < 55; i++) random_view();
    idling = 1'b1;
    settle();

    set_view(32'h0002_0000, 32'hffff_8000, 32'h0010_0000, 32'h0000_4000,
             32'hffff_c000, 32'h0000_2000);
    for (int i = 0; i < 55; i++) begin
      if (i == 30) idling = 1'b0;
      random_view();
    end
    idling = 1'b1;
    settle();

    set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 55; i++) random_view();
    settle();

    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/vmb_pkg.sv
hw/rtl/vmb_unit.sv
hw/rtl/view_matrix_builder.sv
hw/rtl/vmb_checker.sv
sim/vmb_checker.sv
sim/tb_view_matrix_builder.sv
